// ----- sv/semb_pkg.sv -----
// ----------------------------------------------------------------------------
// semb_pkg: shared constants for the semaphore bank with FIFO wait queues
// Field widths, opcodes, error codes and default bank geometry.
// ----------------------------------------------------------------------------
package semb_pkg;

  // Default bank geometry
  localparam int NUM_SEMAPHORES_DEF = 16;
  localparam int MAX_PROCESSES_DEF  = 16;

  // Fixed field widths
  localparam int SEM_IDX_W = 4;
  localparam int PID_W     = 4;
  localparam int ERR_W     = 2;

  // Count limits
  localparam int SEM_COUNT_MAX   = 31;
  localparam int SEM_COUNT_RESET = 1;
  localparam int SEM_COUNT_MIN_W = 6;

  // Opcodes
  localparam logic OP_WAIT   = 1'b0;
  localparam logic OP_SIGNAL = 1'b1;

  // Error codes
  localparam logic [ERR_W-1:0] ERR_NONE = 2'd0;
  localparam logic [ERR_W-1:0] ERR_FULL = 2'd1;
  localparam logic [ERR_W-1:0] ERR_TOP  = 2'd2;

endpackage

// ----- sv/semaphore_bank_fifo_wait_top.sv -----
// An accepted item passes through the count read, the modify step and the queue read before its result is registered.
// A new item is accepted in idle, or in the finishing step when the output register is free, because the
// read-modify-write of the count memory is followed by the registered read of the wait-queue store.
// Reset: control state clears at once; counts read as 1 and queue heads as 0 through one
// valid bit per semaphore, so no clearing pass runs. The wait-queue store is not cleared.
// ----------------------------------------------------------------------------
// semaphore_bank_fifo_wait_top: counting semaphores with FIFO wait queues
// Each semaphore keeps a count and a queue head in a count memory; waiting
// process numbers live in a circular queue per semaphore in a store memory.
// ----------------------------------------------------------------------------
module semaphore_bank_fifo_wait_top #(
  parameter int NUM_SEMAPHORES = semb_pkg::NUM_SEMAPHORES_DEF,
  parameter int MAX_PROCESSES  = semb_pkg::MAX_PROCESSES_DEF
) (
  input  logic       clk,
  input  logic       rst_n,
  // input channel
  input  logic       in_tvalid,
  output logic       in_tready,
  input  logic [7:0] in_tdata,   // [3:0] sem_index, [7:4] process_id
  input  logic       in_tuser,   // [0] opcode
  // result channel
  output logic       out_tvalid,
  input  logic       out_tready,
  output logic [7:0] out_tdata,  // [0] blocked, [4:1] woken_id, [6:5] error, [7] zero
  output logic       out_tuser   // [0] woken_valid
);

  localparam int SEM_AW    = (NUM_SEMAPHORES > 1) ? $clog2(NUM_SEMAPHORES) : 1;
  localparam int HEAD_W    = $clog2(MAX_PROCESSES);
  localparam int CNT_REQ_W = $clog2(MAX_PROCESSES + 1) + 1;
  localparam int CNT_W     = (CNT_REQ_W > semb_pkg::SEM_COUNT_MIN_W) ?
                             CNT_REQ_W : semb_pkg::SEM_COUNT_MIN_W;
  localparam int ENT_W     = CNT_W + HEAD_W;
  localparam int ST_DEPTH  = NUM_SEMAPHORES * MAX_PROCESSES;
  localparam int ST_AW     = $clog2(ST_DEPTH);
  localparam int IDX_EXT_W = 9;

  localparam logic signed [CNT_W-1:0] CNT_MIN  = CNT_W'(-MAX_PROCESSES);
  localparam logic signed [CNT_W-1:0] CNT_TOP  = CNT_W'(semb_pkg::SEM_COUNT_MAX);
  localparam logic signed [CNT_W-1:0] CNT_RST  = CNT_W'(semb_pkg::SEM_COUNT_RESET);
  localparam logic signed [CNT_W-1:0] CNT_ZERO = CNT_W'(0);
  localparam logic [HEAD_W:0]         MAX_HW   = (HEAD_W + 1)'(MAX_PROCESSES);
  localparam logic [ST_AW-1:0]        MAX_SW   = ST_AW'(MAX_PROCESSES);
  localparam logic [IDX_EXT_W-1:0]    NUM_EXT  = IDX_EXT_W'(NUM_SEMAPHORES);

  localparam logic [1:0] S_IDLE  = 2'd0;
  localparam logic [1:0] S_MOD   = 2'd1;
  localparam logic [1:0] S_FETCH = 2'd2;

  // Input field unpacking
  logic                          in_op;
  logic [semb_pkg::SEM_IDX_W-1:0] in_sem;
  logic [semb_pkg::PID_W-1:0]     in_pid;
  logic [IDX_EXT_W-1:0]          in_sem_ext;
  logic                          in_acc;

  assign in_op      = in_tuser;
  assign in_sem     = in_tdata[3:0];
  assign in_pid     = in_tdata[7:4];
  assign in_sem_ext = IDX_EXT_W'(in_sem);
  assign in_acc     = in_tvalid && in_tready;

  // Control and latched item
  logic [1:0]                 state_r, state_nxt;
  logic                       op_r;
  logic [SEM_AW-1:0]          sem_r;
  logic [semb_pkg::PID_W-1:0] pid_r;
  logic                       inr_r;
  logic                       out_ld;

  // Memories
  logic [ENT_W-1:0]           sem_mem [NUM_SEMAPHORES];
  logic [NUM_SEMAPHORES-1:0]  sem_vld_r;
  logic [ENT_W-1:0]           sem_rd_r;
  logic                       vld_rd_r;
  logic [semb_pkg::PID_W-1:0] st_mem [ST_DEPTH];
  logic [semb_pkg::PID_W-1:0] st_rd_r;

  // Modify-stage signals
  logic signed [CNT_W-1:0]    cnt;
  logic signed [CNT_W-1:0]    neg_cnt;
  logic signed [CNT_W-1:0]    cnt_new;
  logic [HEAD_W-1:0]          head;
  logic [HEAD_W-1:0]          head_new;
  logic [HEAD_W:0]            pos_sum;
  logic [HEAD_W:0]            pos_wrap;
  logic [HEAD_W:0]            head_inc;
  logic [ST_AW-1:0]           st_base;
  logic [ST_AW-1:0]           st_addr;
  logic                       sem_we;
  logic                       st_we;
  logic                       st_re;
  logic                       res_blk;
  logic                       res_wv;
  logic [semb_pkg::ERR_W-1:0] res_err;

  // Result registers
  logic                       res_blk_r;
  logic                       res_wv_r;
  logic [semb_pkg::ERR_W-1:0] res_err_r;
  logic                       out_tvalid_r;
  logic                       out_blk_r;
  logic                       out_wv_r;
  logic [semb_pkg::PID_W-1:0] out_wid_r;
  logic [semb_pkg::ERR_W-1:0] out_err_r;

  // Accept in idle, or while finishing when the output register is free
  assign out_ld    = !out_tvalid_r || out_tready;
  assign in_tready = (state_r == S_IDLE) || ((state_r == S_FETCH) && out_ld);

  // Advance the sequencer
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_IDLE: begin
        if (in_acc) state_nxt = S_MOD;
      end
      S_MOD: begin
        state_nxt = S_FETCH;
      end
      S_FETCH: begin
        if (out_ld) state_nxt = in_acc ? S_MOD : S_IDLE;
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  // Latch the accepted item
  always_ff @(posedge clk) begin
    if (in_acc) begin
      op_r  <= in_op;
      sem_r <= in_sem_ext[SEM_AW-1:0];
      pid_r <= in_pid;
      inr_r <= (in_sem_ext < NUM_EXT);
    end
  end

  // Read the count entry on accept
  always_ff @(posedge clk) begin
    if (in_acc) begin
      sem_rd_r <= sem_mem[in_sem_ext[SEM_AW-1:0]];
      vld_rd_r <= sem_vld_r[in_sem_ext[SEM_AW-1:0]];
    end
  end

  // Write back the count entry
  always_ff @(posedge clk) begin
    if (sem_we) begin
      sem_mem[sem_r] <= {cnt_new, head_new};
    end
  end

  // Mark entries written since reset
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sem_vld_r <= '0;
    end else if (sem_we) begin
      sem_vld_r[sem_r] <= 1'b1;
    end
  end

  // Queue store: append on a blocking wait, read the head on a wake
  always_ff @(posedge clk) begin
    if (st_we) begin
      st_mem[st_addr] <= pid_r;
    end
    if (st_re) begin
      st_rd_r <= st_mem[st_addr];
    end
  end

  // Decode the count entry; unwritten entries read as reset values
  assign cnt      = vld_rd_r ? $signed(sem_rd_r[ENT_W-1:HEAD_W]) : CNT_RST;
  assign head     = vld_rd_r ? sem_rd_r[HEAD_W-1:0] : '0;
  assign neg_cnt  = -cnt;
  assign pos_sum  = {1'b0, head} + {1'b0, neg_cnt[HEAD_W-1:0]};
  assign pos_wrap = (pos_sum >= MAX_HW) ? (pos_sum - MAX_HW) : pos_sum;
  assign head_inc = {1'b0, head} + (HEAD_W + 1)'(1);
  assign st_base  = ST_AW'(sem_r) * MAX_SW;

  // Modify the count and queue for the item in flight
  always_comb begin
    cnt_new  = cnt;
    head_new = head;
    sem_we   = 1'b0;
    st_we    = 1'b0;
    st_re    = 1'b0;
    st_addr  = st_base + ST_AW'(head);
    res_blk  = 1'b0;
    res_wv   = 1'b0;
    res_err  = semb_pkg::ERR_NONE;
    if ((state_r == S_MOD) && inr_r) begin
      if (op_r == semb_pkg::OP_WAIT) begin
        if (cnt == CNT_MIN) begin
          res_err = semb_pkg::ERR_FULL;
        end else begin
          cnt_new = cnt - CNT_W'(1);
          sem_we  = 1'b1;
          if (cnt <= CNT_ZERO) begin
            st_we   = 1'b1;
            st_addr = st_base + ST_AW'(pos_wrap[HEAD_W-1:0]);
            res_blk = 1'b1;
          end
        end
      end else begin
        if (cnt >= CNT_TOP) begin
          res_err = semb_pkg::ERR_TOP;
        end else begin
          cnt_new = cnt + CNT_W'(1);
          sem_we  = 1'b1;
          if (cnt < CNT_ZERO) begin
            st_re    = 1'b1;
            res_wv   = 1'b1;
            head_new = (head_inc == MAX_HW) ? '0 : head_inc[HEAD_W-1:0];
          end
        end
      end
    end
  end

  // Hold the result flags until the queue read returns
  always_ff @(posedge clk) begin
    if (state_r == S_MOD) begin
      res_blk_r <= res_blk;
      res_wv_r  <= res_wv;
      res_err_r <= res_err;
    end
  end

  // Output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_tvalid_r <= 1'b0;
    end else if ((state_r == S_FETCH) && out_ld) begin
      out_tvalid_r <= 1'b1;
    end else if (out_tready) begin
      out_tvalid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if ((state_r == S_FETCH) && out_ld) begin
      out_blk_r <= res_blk_r;
      out_wv_r  <= res_wv_r;
      out_wid_r <= res_wv_r ? st_rd_r : '0;
      out_err_r <= res_err_r;
    end
  end

  assign out_tvalid = out_tvalid_r;
  assign out_tdata  = {1'b0, out_err_r, out_wid_r, out_blk_r};
  assign out_tuser  = out_wv_r;

  // Checks
  a_item_to_mod: assert property (@(posedge clk) disable iff (!rst_n)
    in_acc |=> (state_r == S_MOD))
    else $error("accepted item did not enter the modify step");

  a_result_from_fetch: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_tvalid) |-> $past(state_r == S_FETCH))
    else $error("result appeared without a finishing step");

  a_store_one_access: assert property (@(posedge clk) disable iff (!rst_n)
    !(st_we && st_re))
    else $error("queue store written and read in the same cycle");

  a_blocked_xor_woken: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> !(out_blk_r && out_wv_r))
    else $error("result both blocked and woken");

  a_error_no_effect: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_MOD && res_err != semb_pkg::ERR_NONE) |-> (!sem_we && !st_we && !st_re))
    else $error("refused item changed state");

endmodule
